[design/cnsr_pkg.sv]
// Shared constants and types for the cross-neighbour spike removal block.
// No dependencies; used by the stream interfaces, the divider and the top level.
package cnsr_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int IN_PIXEL_W  = 8;
  localparam int OUT_PIXEL_W = 8;

  localparam int CFG_DIM_W  = 11;
  localparam int CFG_THR_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH     = 11'd30;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT    = 11'd20;
  localparam logic [CFG_THR_W-1:0] RST_SPIKE_THRESHOLD = 8'd1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_SPIKE_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[design/cnsr_in_if.sv]
// Raw pixel stream channel: valid/ready handshake with pixel and flush payload.
// Depends on cnsr_pkg for field widths.
interface cnsr_in_if;
  logic                             valid;
  logic                             ready;
  logic [cnsr_pkg::IN_PIXEL_W-1:0]  pixel_in;
  logic                             is_flush;

  modport source (output valid, output pixel_in, output is_flush, input ready);
  modport sink   (input valid, input pixel_in, input is_flush, output ready);
endinterface

[design/cnsr_out_if.sv]
// Filtered pixel stream channel: valid/ready handshake with pixel and frame-end flag.
// Depends on cnsr_pkg for field widths.
interface cnsr_out_if;
  logic                             valid;
  logic                             ready;
  logic [cnsr_pkg::OUT_PIXEL_W-1:0] pixel_out;
  logic                             frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

[design/cnsr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on cnsr_pkg for the status struct.
module cnsr_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIVIDEND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output logic [DIVIDEND_W-1:0]  quotient,
  output logic [DIVISOR_W-1:0]   remainder,
  output cnsr_pkg::div_status_t  status
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     steps;
  logic                  done;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(DIVIDEND_W);
      end else if (steps != '0) begin
        steps <= steps - STEP_W'(1);
        done  <= (steps == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[DIVIDEND_W-2:0], ge};
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = (steps != '0) || done;
  assign status.done = done;

endmodule

[design/cross_neighbour_spike_removal.sv]
// Cross-neighbour spike removal top level: APB registers, line window, filter pipeline.
// Depends on cnsr_pkg, cnsr_in_if, cnsr_out_if and cnsr_div.
//
// Takes one transfer (pixel or flush) per clock unless the output stalls or the
// divider is busy, and returns the filtered pixel of a position through stage 1,
// stage 2 and the output register after the transfer that releases it. The rate
// is set by the line window: two copies of a 2*MAX_WIDTH+1 entry memory, each
// giving two registered reads per cycle (up/down from one, centre/right from the
// other), the left neighbour taken from the previous centre. Pixel k leaves once
// pixel k+frame_width has arrived; flush transfers drain the last row, and
// frame_last marks the final pixel. After a write to frame_width the input holds
// ready low while a bit-serial divider recomputes the row and column of the
// pending output. The window needs no clearing after reset.
module cross_neighbour_spike_removal #(
  parameter int MAX_WIDTH  = cnsr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnsr_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = cnsr_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  cnsr_in_if.sink                           pixels,
  cnsr_out_if.source                        filtered,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cnsr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cnsr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cnsr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int WIN_DEPTH = 2 * MAX_WIDTH + 1;
  localparam int PTR_W     = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int XW        = CNT_W + 1;
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int DIM_W     = cnsr_pkg::CFG_DIM_W;
  localparam int THR_W     = cnsr_pkg::CFG_THR_W;
  localparam int CWW       = (WID_W > DIM_W) ? WID_W : DIM_W;
  localparam int CWH       = (HGT_W > DIM_W) ? HGT_W : DIM_W;
  localparam int SUM_W     = PIXEL_BITS + 2;
  localparam int CMP_W     = ((PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W) + 1;
  localparam int IW        = (PIXEL_BITS > cnsr_pkg::IN_PIXEL_W) ? PIXEL_BITS
                                                                 : cnsr_pkg::IN_PIXEL_W;
  localparam int OW        = (PIXEL_BITS > cnsr_pkg::OUT_PIXEL_W) ? PIXEL_BITS
                                                                  : cnsr_pkg::OUT_PIXEL_W;
  localparam int unsigned DIV3_SHIFT = SUM_W + 2;
  localparam int unsigned DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int PROD_W    = SUM_W + DIV3_SHIFT;

  // ---------------------------------------------------------------- registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [THR_W-1:0] spike_threshold;

  logic               cfg_wr;
  cnsr_pkg::cfg_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cnsr_pkg::cfg_reg_t'(paddr[cnsr_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= cnsr_pkg::RST_FRAME_WIDTH;
      frame_height    <= cnsr_pkg::RST_FRAME_HEIGHT;
      spike_threshold <= cnsr_pkg::RST_SPIKE_THRESHOLD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cnsr_pkg::REG_FRAME_WIDTH:     frame_width     <= pwdata[DIM_W-1:0];
        cnsr_pkg::REG_FRAME_HEIGHT:    frame_height    <= pwdata[DIM_W-1:0];
        cnsr_pkg::REG_SPIKE_THRESHOLD: spike_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cnsr_pkg::REG_FRAME_WIDTH:     prdata = cnsr_pkg::CFG_DATA_W'(frame_width);
      cnsr_pkg::REG_FRAME_HEIGHT:    prdata = cnsr_pkg::CFG_DATA_W'(frame_height);
      cnsr_pkg::REG_SPIKE_THRESHOLD: prdata = cnsr_pkg::CFG_DATA_W'(spike_threshold);
      default:                       prdata = '0;
    endcase
  end

  function automatic logic [WID_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return WID_W'(1);
    end else if (CWW'(v) > CWW'(MAX_WIDTH)) begin
      return WID_W'(MAX_WIDTH);
    end
    return WID_W'(v);
  endfunction

  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;
  logic [CNT_W-1:0] total;

  assign eff_w = clamp_width(frame_width);

  always_comb begin
    if (frame_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (CWH'(frame_height) > CWH'(MAX_HEIGHT)) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(frame_height);
    end
  end

  assign total = CNT_W'(eff_w) * CNT_W'(eff_h);

  // ---------------------------------------------------------------- position state
  logic [CNT_W-1:0] in_cnt, out_cnt;
  logic [PTR_W-1:0] wr_ptr, ctr_ptr;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  logic [CNT_W-1:0] in_cnt_next, out_cnt_next;
  logic [PTR_W-1:0] wr_ptr_next, ctr_ptr_next;
  logic [ROW_W-1:0] out_row_next;
  logic [COL_W-1:0] out_col_next;

  cnsr_pkg::div_status_t div_status;
  logic [CNT_W-1:0]      div_quo;
  logic [WID_W-1:0]      div_rem;
  logic                  div_start;

  assign div_start = cfg_wr && (cfg_idx == cnsr_pkg::REG_FRAME_WIDTH);

  cnsr_div #(
    .DIVIDEND_W (CNT_W),
    .DIVISOR_W  (WID_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (out_cnt),
    .divisor   (clamp_width(pwdata[DIM_W-1:0])),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_status)
  );

  // pipeline enables
  logic out_valid, s1_valid, s2_valid;
  logic out_en, s2_en, s1_en, accept;

  assign out_en       = !out_valid || filtered.ready;
  assign s2_en        = !s2_valid || out_en;
  assign s1_en        = !s1_valid || s2_en;
  assign pixels.ready = s1_en && !div_status.busy;
  assign accept       = pixels.valid && pixels.ready;

  // accept-side control
  logic             wrap, full, store, emit, last;
  logic             has_up, has_down, has_left, has_right;
  logic [CNT_W-1:0] ic0, oc0, ic1;
  logic [PTR_W-1:0] wp0, cp0;
  logic [ROW_W-1:0] row0;
  logic [COL_W-1:0] col0;
  logic [PTR_W-1:0] up_addr, down_addr, right_addr, wp_inc;
  logic [PTR_W:0]   down_sum;
  logic [IW-1:0]    in_wide;
  logic [PIXEL_BITS-1:0] wdata;

  assign in_wide = IW'(pixels.pixel_in);
  assign wdata   = in_wide[PIXEL_BITS-1:0];

  always_comb begin
    wrap = out_cnt >= total;
    ic0  = wrap ? '0 : in_cnt;
    oc0  = wrap ? '0 : out_cnt;
    wp0  = wrap ? '0 : wr_ptr;
    cp0  = wrap ? '0 : ctr_ptr;
    row0 = wrap ? '0 : out_row;
    col0 = wrap ? '0 : out_col;

    full  = ic0 >= total;
    store = !pixels.is_flush && !full;
    ic1   = store ? ic0 + CNT_W'(1) : ic0;

    if (pixels.is_flush) begin
      emit = oc0 < ic0;
    end else begin
      emit = store && (XW'(oc0) + XW'(eff_w) < XW'(ic1));
    end

    has_up    = row0 != '0;
    has_down  = ((HGT_W + 1)'(row0) + (HGT_W + 1)'(1) < (HGT_W + 1)'(eff_h))
                && (XW'(oc0) + XW'(eff_w) < XW'(ic1));
    has_left  = col0 != '0;
    has_right = ((WID_W + 1)'(col0) + (WID_W + 1)'(1) < (WID_W + 1)'(eff_w))
                && (XW'(oc0) + XW'(1) < XW'(ic1));
    last      = (XW'(oc0) + XW'(1)) == XW'(total);

    right_addr = (cp0 == PTR_W'(WIN_DEPTH - 1)) ? '0 : cp0 + PTR_W'(1);
    wp_inc     = (wp0 == PTR_W'(WIN_DEPTH - 1)) ? '0 : wp0 + PTR_W'(1);
    if ((PTR_W + 1)'(cp0) >= (PTR_W + 1)'(eff_w)) begin
      up_addr = PTR_W'((PTR_W + 1)'(cp0) - (PTR_W + 1)'(eff_w));
    end else begin
      up_addr = PTR_W'((PTR_W + 1)'(cp0) + (PTR_W + 1)'(WIN_DEPTH) - (PTR_W + 1)'(eff_w));
    end
    down_sum = (PTR_W + 1)'(cp0) + (PTR_W + 1)'(eff_w);
    if (down_sum >= (PTR_W + 1)'(WIN_DEPTH)) begin
      down_addr = PTR_W'(down_sum - (PTR_W + 1)'(WIN_DEPTH));
    end else begin
      down_addr = down_sum[PTR_W-1:0];
    end

    in_cnt_next  = ic1;
    wr_ptr_next  = store ? wp_inc : wp0;
    out_cnt_next = oc0;
    ctr_ptr_next = cp0;
    out_row_next = row0;
    out_col_next = col0;
    if (emit) begin
      out_cnt_next = oc0 + CNT_W'(1);
      ctr_ptr_next = right_addr;
      if ((WID_W + 1)'(col0) + (WID_W + 1)'(1) == (WID_W + 1)'(eff_w)) begin
        out_col_next = '0;
        out_row_next = row0 + ROW_W'(1);
      end else begin
        out_col_next = col0 + COL_W'(1);
      end
      if (last) begin
        in_cnt_next  = '0;
        wr_ptr_next  = '0;
        out_cnt_next = '0;
        ctr_ptr_next = '0;
        out_row_next = '0;
        out_col_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_cnt <= '0;
      wr_ptr  <= '0;
      ctr_ptr <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      in_cnt  <= in_cnt_next;
      out_cnt <= out_cnt_next;
      wr_ptr  <= wr_ptr_next;
      ctr_ptr <= ctr_ptr_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end else if (div_status.done) begin
      out_row <= div_quo[ROW_W-1:0];
      out_col <= div_rem[COL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- line window
  logic [PIXEL_BITS-1:0] win_a [0:WIN_DEPTH-1];
  logic [PIXEL_BITS-1:0] win_b [0:WIN_DEPTH-1];
  logic                  we;
  logic [PIXEL_BITS-1:0] rd_up, rd_down, rd_ctr, rd_right;

  assign we = accept && store;

  always_ff @(posedge clk) begin
    if (we) begin
      win_a[wp0] <= wdata;
    end
    if (s1_en) begin
      rd_up   <= (we && wp0 == up_addr)   ? wdata : win_a[up_addr];
      rd_down <= (we && wp0 == down_addr) ? wdata : win_a[down_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      win_b[wp0] <= wdata;
    end
    if (s1_en) begin
      rd_ctr   <= (we && wp0 == cp0)        ? wdata : win_b[cp0];
      rd_right <= (we && wp0 == right_addr) ? wdata : win_b[right_addr];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic s1_up, s1_down, s1_left, s1_right, s1_last;
  logic [PIXEL_BITS-1:0] prev_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_up    <= has_up;
      s1_down  <= has_down;
      s1_left  <= has_left;
      s1_right <= has_right;
      s1_last  <= last;
    end
    if (s1_valid && s2_en) begin
      prev_ctr <= rd_ctr;
    end
  end

  function automatic logic above(input logic [PIXEL_BITS-1:0] p,
                                 input logic [PIXEL_BITS-1:0] nb,
                                 input logic [THR_W-1:0] t);
    return CMP_W'(p) > CMP_W'(nb) + CMP_W'(t);
  endfunction

  logic [SUM_W-1:0] nb_sum;
  logic [2:0]       nb_count;
  logic             spike;

  always_comb begin
    nb_sum   = '0;
    nb_count = '0;
    spike    = 1'b1;
    if (s1_up) begin
      nb_sum   = nb_sum + SUM_W'(rd_up);
      nb_count = nb_count + 3'd1;
      spike    = spike && above(rd_ctr, rd_up, spike_threshold);
    end
    if (s1_down) begin
      nb_sum   = nb_sum + SUM_W'(rd_down);
      nb_count = nb_count + 3'd1;
      spike    = spike && above(rd_ctr, rd_down, spike_threshold);
    end
    if (s1_left) begin
      nb_sum   = nb_sum + SUM_W'(prev_ctr);
      nb_count = nb_count + 3'd1;
      spike    = spike && above(rd_ctr, prev_ctr, spike_threshold);
    end
    if (s1_right) begin
      nb_sum   = nb_sum + SUM_W'(rd_right);
      nb_count = nb_count + 3'd1;
      spike    = spike && above(rd_ctr, rd_right, spike_threshold);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [SUM_W-1:0]      s2_sum;
  logic [2:0]            s2_n;
  logic                  s2_spike, s2_last;
  logic [PIXEL_BITS-1:0] s2_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_sum   <= nb_sum;
      s2_n     <= nb_count;
      s2_spike <= spike;
      s2_last  <= s1_last;
      s2_ctr   <= rd_ctr;
    end
  end

  logic [PROD_W-1:0]     prod3;
  logic [PIXEL_BITS-1:0] mean, result;
  logic [OW-1:0]         res_wide;

  assign prod3 = PROD_W'(s2_sum) * PROD_W'(DIV3_MUL);

  always_comb begin
    case (s2_n)
      3'd1:    mean = s2_sum[PIXEL_BITS-1:0];
      3'd2:    mean = s2_sum[1 +: PIXEL_BITS];
      3'd3:    mean = prod3[DIV3_SHIFT +: PIXEL_BITS];
      3'd4:    mean = s2_sum[2 +: PIXEL_BITS];
      default: mean = s2_ctr;
    endcase
  end

  assign result   = (s2_spike && s2_n != 3'd0) ? mean : s2_ctr;
  assign res_wide = OW'(result);

  // ---------------------------------------------------------------- output register
  logic [cnsr_pkg::OUT_PIXEL_W-1:0] out_pix;
  logic                             out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_pix  <= res_wide[cnsr_pkg::OUT_PIXEL_W-1:0];
      out_last <= s2_last;
    end
  end

  assign filtered.valid      = out_valid;
  assign filtered.pixel_out  = out_pix;
  assign filtered.frame_last = out_last;

`ifndef SYNTHESIS
  a_out_behind_in : assert property (@(posedge clk) disable iff (rst)
    out_cnt <= in_cnt)
    else $error("output count ran ahead of input count");

  a_wr_ptr_frame_start : assert property (@(posedge clk) disable iff (rst)
    (in_cnt == '0) |-> (wr_ptr == '0))
    else $error("write pointer not aligned with frame start");

  a_out_pos_frame_start : assert property (@(posedge clk) disable iff (rst)
    (out_cnt == '0) |-> (ctr_ptr == '0 && out_row == '0 && out_col == '0))
    else $error("output position not aligned with frame start");

  a_div_hold : assert property (@(posedge clk) disable iff (rst)
    div_status.done |=> $stable(in_cnt) && $stable(out_cnt))
    else $error("counters moved while row and column were recomputed");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for cross_neighbour_spike_removal: directed and random frames with
// random idling on both streams, checked against an in-bench scoreboard of the filter.
// Depends on cnsr_pkg, cnsr_in_if, cnsr_out_if and the block itself.
module tb_top;
  import cnsr_pkg::*;

  localparam int WINDOW_DEPTH = 2 * MAX_WIDTH_DEF + 1;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [OUT_PIXEL_W-1:0] pixel;
    logic                   last;
  } filtered_t;

  class spike_filter_scoreboard;
    logic [IN_PIXEL_W-1:0] window [WINDOW_DEPTH];
    int unsigned           in_cnt;
    int unsigned           out_cnt;
    logic [CFG_DIM_W-1:0]  width_reg;
    logic [CFG_DIM_W-1:0]  height_reg;
    logic [CFG_THR_W-1:0]  thr_reg;
    filtered_t             pending_pixels [$];
    int                    errors;

    function new();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      thr_reg    = RST_SPIKE_THRESHOLD;
      in_cnt     = 0;
      out_cnt    = 0;
      errors     = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
      return height_reg;
    endfunction

    function int unsigned frame_total();
      return eff_width() * eff_height();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH:     width_reg  = value[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:    height_reg = value[CFG_DIM_W-1:0];
        REG_SPIKE_THRESHOLD: thr_reg    = value[CFG_THR_W-1:0];
        default: ;
      endcase
    endfunction

    // neighbours not yet received (below or to the right) count as absent
    function logic [OUT_PIXEL_W-1:0] filtered_value(int unsigned k, int unsigned w,
                                                    int unsigned h);
      int unsigned row;
      int unsigned col;
      int unsigned n;
      int unsigned sum;
      int          centre;
      int          nb [4];
      bit          spike;
      row    = k / w;
      col    = k % w;
      n      = 0;
      sum    = 0;
      spike  = 1'b1;
      centre = window[k % WINDOW_DEPTH];
      if (row > 0) begin
        nb[n] = window[(k - w) % WINDOW_DEPTH];
        n++;
      end
      if (row + 1 < h && k + w < in_cnt) begin
        nb[n] = window[(k + w) % WINDOW_DEPTH];
        n++;
      end
      if (col > 0) begin
        nb[n] = window[(k - 1) % WINDOW_DEPTH];
        n++;
      end
      if (col + 1 < w && k + 1 < in_cnt) begin
        nb[n] = window[(k + 1) % WINDOW_DEPTH];
        n++;
      end
      if (n == 0) return OUT_PIXEL_W'(centre);
      for (int i = 0; i < n; i++) begin
        sum += nb[i];
        if (centre - nb[i] <= int'(thr_reg)) spike = 1'b0;
      end
      return spike ? OUT_PIXEL_W'(sum / n) : OUT_PIXEL_W'(centre);
    endfunction

    // returns 1 unless the transfer left the block untouched
    function bit note_transfer(logic [IN_PIXEL_W-1:0] pixel, logic flush);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      bit          emit;
      filtered_t   res;
      w     = eff_width();
      h     = eff_height();
      total = w * h;
      if (out_cnt >= total) begin
        in_cnt  = 0;
        out_cnt = 0;
      end
      if (flush) begin
        emit = out_cnt < in_cnt;
      end else begin
        if (in_cnt >= total) return 1'b0;
        window[in_cnt % WINDOW_DEPTH] = pixel;
        in_cnt++;
        emit = out_cnt + w < in_cnt;
      end
      if (!emit) return !flush;
      res.pixel = filtered_value(out_cnt, w, h);
      res.last  = (out_cnt + 1 == total);
      pending_pixels.push_back(res);
      out_cnt++;
      if (out_cnt >= total) begin
        in_cnt  = 0;
        out_cnt = 0;
      end
      return 1'b1;
    endfunction

    function void check_filtered(filtered_t got);
      filtered_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: pixel %0d last %0b", got.pixel, got.last);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel !== want.pixel || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   want.pixel, want.last, got.pixel, got.last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cnsr_in_if  pixels_if ();
  cnsr_out_if filtered_if ();

  spike_filter_scoreboard sb;
  int          items_done;
  int          idle_cycles;
  bit          send_calm;
  bit          take_calm;
  int unsigned bg_level;

  cross_neighbour_spike_removal uut (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels_if),
    .filtered (filtered_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [IN_PIXEL_W-1:0] next_pixel();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'd255;
    if (r == 1) return 8'd0;
    if (r < 6) return IN_PIXEL_W'($urandom);
    v = bg_level + $urandom_range(0, 12);
    return (v > 255) ? 8'd255 : IN_PIXEL_W'(v);
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic [IN_PIXEL_W-1:0] pixel, input logic flush);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    @(negedge clk);
    if (gap > 0) begin
      pixels_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixels_if.valid    <= 1'b1;
    pixels_if.pixel_in <= pixel;
    pixels_if.is_flush <= flush;
    do @(posedge clk); while (!pixels_if.ready);
    if (sb.note_transfer(pixel, flush)) items_done++;
  endtask

  // drop valid, let every expected pixel arrive, then allow the pipeline to settle
  task automatic wait_idle();
    @(negedge clk);
    pixels_if.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // run the current frame to its end so that both counts are back at zero
  task automatic finish_frame();
    while (sb.in_cnt != 0 || sb.out_cnt != 0) begin
      if (sb.out_cnt >= sb.frame_total() || sb.in_cnt >= sb.frame_total())
        send_item(IN_PIXEL_W'($urandom), 1'b1);
      else
        send_item(next_pixel(), 1'b0);
    end
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = take_calm ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      @(negedge clk);
      if (stall > 0) begin
        filtered_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      filtered_if.ready <= 1'b1;
      do @(posedge clk); while (!filtered_if.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && filtered_if.valid && filtered_if.ready)
      sb.check_filtered(filtered_t'{pixel: filtered_if.pixel_out,
                                    last: filtered_if.frame_last});
    if (rst || (pixels_if.valid && pixels_if.ready) ||
        (filtered_if.valid && filtered_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** cross_neighbour_spike_removal: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [IN_PIXEL_W-1:0] spot [9];
    int unsigned           w;
    int unsigned           h;
    clk                = 1'b0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pixels_if.valid    = 1'b0;
    pixels_if.pixel_in = '0;
    pixels_if.is_flush = 1'b0;
    filtered_if.ready  = 1'b0;
    items_done         = 0;
    idle_cycles        = 0;
    send_calm          = 1'b0;
    take_calm          = 1'b0;
    bg_level           = 64;
    sb                 = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // 3x3: corner and centre spikes, pixel past the frame end, flush with nothing pending
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_SPIKE_THRESHOLD, 0);
    spot = '{8'd200, 8'd10, 8'd255, 8'd20, 8'd255, 8'd30, 8'd0, 8'd40, 8'd128};
    foreach (spot[i]) send_item(spot[i], 1'b0);
    send_item(8'd77, 1'b0);
    repeat (4) send_item(8'd0, 1'b1);
    wait_idle();

    // single pixel frame, then a single row where each pixel has one neighbour
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b1);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    repeat (2) send_item(8'd0, 1'b1);
    wait_idle();

    // early flush: right and lower neighbours not yet in
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 2);
    send_item(8'd9, 1'b0);
    send_item(8'd250, 1'b0);
    repeat (2) send_item(8'd0, 1'b1);
    finish_frame();
    wait_idle();

    // height cut mid-frame below the output count
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 4);
    write_reg(REG_SPIKE_THRESHOLD, 255);
    repeat (6) send_item(next_pixel(), 1'b0);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 1);

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 2) == 0) begin
        finish_frame();
        wait_idle();
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
      end else if ($urandom_range(0, 3) == 0 && sb.eff_width() <= 16) begin
        write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 6));
      end
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_SPIKE_THRESHOLD, ($urandom_range(0, 5) == 0) ?
                  ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 40));
      bg_level = $urandom_range(0, 255);
      repeat ($urandom_range(10, 150)) begin
        if (sb.in_cnt >= sb.frame_total() ? $urandom_range(0, 7) != 0
                                          : $urandom_range(0, 11) == 0)
          send_item(IN_PIXEL_W'($urandom), 1'b1);
        else
          send_item(next_pixel(), 1'b0);
      end
    end

    // largest frames: one full-width row, one full-height column
    finish_frame();
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_SPIKE_THRESHOLD, 0);
    send_item(next_pixel(), 1'b0);
    finish_frame();
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 2047);
    write_reg(REG_SPIKE_THRESHOLD, 3);
    send_item(next_pixel(), 1'b0);
    finish_frame();

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** cross_neighbour_spike_removal: PASSED **");
    end else begin
      $display("** cross_neighbour_spike_removal: FAILED **");
    end
    $finish;
  end

endmodule
